[src/pcmm_pkg.sv]
package pcmm_pkg;

  localparam int CHANNELS    = 36;
  localparam int SAMPLE_BITS = 16;
  localparam int CHAN_BITS   = 6;
  localparam int SUM_BITS    = 48;
  localparam int COUNT_BITS  = 32;
  localparam int ENTRIES     = 2 * CHANNELS;
  localparam int IDX_BITS    = $clog2(ENTRIES);
  localparam int STEP_BITS   = $clog2(SUM_BITS);

  // one statistics entry per quantity/channel pair
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] min_val;
    logic [SAMPLE_BITS-1:0] max_val;
    logic [SUM_BITS-1:0]    sum_val;
  } entry_t;

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

[src/pcmm_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module pcmm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcmm_pkg::div_req_t  req_i,
  output pcmm_pkg::div_rsp_t  rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [pcmm_pkg::STEP_BITS-1:0]      cnt_q;
  logic [pcmm_pkg::COUNT_BITS-1:0]     rem_q;
  logic [pcmm_pkg::COUNT_BITS-1:0]     dsr_q;
  logic [pcmm_pkg::SUM_BITS-1:0]       quo_q;

  logic [pcmm_pkg::COUNT_BITS:0]       shifted;
  logic [pcmm_pkg::COUNT_BITS:0]       trial;
  logic                                q_bit;
  logic [pcmm_pkg::COUNT_BITS-1:0]     rem_d;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_q, quo_q[pcmm_pkg::SUM_BITS-1]};
    trial   = shifted - {1'b0, dsr_q};
    q_bit   = ~trial[pcmm_pkg::COUNT_BITS];
    rem_d   = q_bit ? trial[pcmm_pkg::COUNT_BITS-1:0] : shifted[pcmm_pkg::COUNT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == pcmm_pkg::STEP_BITS'(pcmm_pkg::SUM_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dsr_q <= req_i.divisor;
      quo_q <= req_i.dividend;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[pcmm_pkg::SUM_BITS-2:0], q_bit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[src/per_channel_min_max_mean_tracker.sv]
// Per-channel running min/max/mean tracker. Each input word is one sample for one
// channel of the voltage (req_type 0) or current (req_type 1) quantity; a sample with
// row_start set first bumps that quantity's row count (saturating at 32 bits). The
// block then folds the sample into the channel's running minimum, maximum and 48-bit
// saturating sum and returns one result word: min, max, spread (max - min) and mean
// (sum / row count, truncated, saturated to all ones, zero while no row has started).
// A channel index at or beyond CHANNELS returns channel_error with all other fields
// zero and leaves every statistic untouched. The statistics live in one 72 x 80 bit
// single-port memory with a registered read, plus one valid flip-flop per entry
// that reset clears, so no clearing pass is needed. One item is worked on at a time:
// a normal sample passes the read and update states, then waits in the divide state
// for the 48-step radix-2 divider that forms the mean; a sample with a zero row count
// skips the divide, and an out-of-range channel goes straight to done. A finished
// result sits in the output register while the next sample is accepted and read.
module per_channel_min_max_mean_tracker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [pcmm_pkg::CHAN_BITS-1:0]   channel_i,
  input  logic [pcmm_pkg::SAMPLE_BITS-1:0] sample_value_i,
  input  logic                             row_start_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pcmm_pkg::SAMPLE_BITS-1:0] min_value_o,
  output logic [pcmm_pkg::SAMPLE_BITS-1:0] max_value_o,
  output logic signed [pcmm_pkg::SAMPLE_BITS:0] spread_o,
  output logic [pcmm_pkg::SAMPLE_BITS-1:0] mean_value_o,
  output logic                             channel_error_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  // statistics memory and its per-entry valid bits
  pcmm_pkg::entry_t             mem [pcmm_pkg::ENTRIES];
  logic [pcmm_pkg::ENTRIES-1:0] vld_q;
  pcmm_pkg::entry_t             rd_data_q;
  logic                         ent_vld_q;

  // the item at work
  logic                              kind_q;
  logic [pcmm_pkg::IDX_BITS-1:0]     idx_q;
  logic [pcmm_pkg::SAMPLE_BITS-1:0]  sample_q;
  logic                              err_q;
  logic [pcmm_pkg::SAMPLE_BITS-1:0]  min_q, max_q, mean_q;

  logic [pcmm_pkg::COUNT_BITS-1:0]   volt_rows_q, cur_rows_q;

  // output register
  logic                              out_valid_q;
  logic [pcmm_pkg::SAMPLE_BITS-1:0]  out_min_q, out_max_q, out_mean_q;
  logic signed [pcmm_pkg::SAMPLE_BITS:0] out_spread_q;
  logic                              out_err_q;

  logic                              in_fire, out_load;
  logic                              chan_err;
  logic [pcmm_pkg::IDX_BITS-1:0]     addr;
  pcmm_pkg::entry_t                  old_ent, new_ent;
  logic [pcmm_pkg::SUM_BITS:0]       sum_ext;
  logic [pcmm_pkg::COUNT_BITS-1:0]   rows;
  logic [pcmm_pkg::SAMPLE_BITS-1:0]  mean_sat;

  pcmm_pkg::div_req_t div_req;
  pcmm_pkg::div_rsp_t div_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign chan_err = {1'b0, channel_i} >= (pcmm_pkg::CHAN_BITS + 1)'(pcmm_pkg::CHANNELS);
  assign addr     = pcmm_pkg::IDX_BITS'(channel_i)
                  + (req_type_i ? pcmm_pkg::IDX_BITS'(pcmm_pkg::CHANNELS) : '0);

  // read-modify of the fetched entry; an entry never written reads as its reset value
  always_comb begin
    if (ent_vld_q) begin
      old_ent = rd_data_q;
    end else begin
      old_ent.min_val = '1;
      old_ent.max_val = '0;
      old_ent.sum_val = '0;
    end
    new_ent.min_val = (sample_q < old_ent.min_val) ? sample_q : old_ent.min_val;
    new_ent.max_val = (sample_q > old_ent.max_val) ? sample_q : old_ent.max_val;
    sum_ext = {1'b0, old_ent.sum_val} + (pcmm_pkg::SUM_BITS + 1)'(sample_q);
    new_ent.sum_val = sum_ext[pcmm_pkg::SUM_BITS] ? '1 : sum_ext[pcmm_pkg::SUM_BITS-1:0];
    rows = kind_q ? cur_rows_q : volt_rows_q;
  end

  // clip the quotient to the sample range
  assign mean_sat = (|div_rsp.quotient[pcmm_pkg::SUM_BITS-1:pcmm_pkg::SAMPLE_BITS])
                  ? '1 : div_rsp.quotient[pcmm_pkg::SAMPLE_BITS-1:0];

  assign div_req.start    = (state_q == ST_UPD) && (rows != '0);
  assign div_req.dividend = new_ent.sum_val;
  assign div_req.divisor  = rows;

  pcmm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = chan_err ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = (rows != '0) ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vld_q       <= '0;
      volt_rows_q <= '0;
      cur_rows_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // bump the row count at acceptance, so the update sees the new count
      if (in_fire && !chan_err && row_start_i) begin
        if (req_type_i) begin
          cur_rows_q <= (&cur_rows_q) ? cur_rows_q : cur_rows_q + 1'b1;
        end else begin
          volt_rows_q <= (&volt_rows_q) ? volt_rows_q : volt_rows_q + 1'b1;
        end
      end
      if (state_q == ST_UPD) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // memory port: read at acceptance, write back in the update cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_data_q <= mem[addr];
    end
    if (state_q == ST_UPD) begin
      mem[idx_q] <= new_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= req_type_i;
      idx_q     <= addr;
      sample_q  <= sample_value_i;
      err_q     <= chan_err;
      ent_vld_q <= vld_q[addr];
    end
    if (state_q == ST_UPD) begin
      min_q  <= new_ent.min_val;
      max_q  <= new_ent.max_val;
      mean_q <= '0;
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      mean_q <= mean_sat;
    end
    if (out_load) begin
      out_err_q <= err_q;
      if (err_q) begin
        out_min_q    <= '0;
        out_max_q    <= '0;
        out_spread_q <= '0;
        out_mean_q   <= '0;
      end else begin
        out_min_q    <= min_q;
        out_max_q    <= max_q;
        out_spread_q <= $signed({1'b0, max_q} - {1'b0, min_q});
        out_mean_q   <= mean_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign min_value_o     = out_min_q;
  assign max_value_o     = out_max_q;
  assign spread_o        = out_spread_q;
  assign mean_value_o    = out_mean_q;
  assign channel_error_o = out_err_q;

endmodule

[src/pcmm_checker.sv]
module pcmm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [pcmm_pkg::SAMPLE_BITS-1:0] min_value_o,
  input logic [pcmm_pkg::SAMPLE_BITS-1:0] max_value_o,
  input logic signed [pcmm_pkg::SAMPLE_BITS:0] spread_o,
  input logic [pcmm_pkg::SAMPLE_BITS-1:0] mean_value_o,
  input logic                             channel_error_o
);

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_value_o)
      && $stable(max_value_o) && $stable(mean_value_o) && $stable(channel_error_o))
    else $error("stalled result word changed or dropped");

  // a rejected channel reports all-zero statistics
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_error_o |-> min_value_o == '0 && max_value_o == '0
      && spread_o == '0 && mean_value_o == '0)
    else $error("channel error with nonzero statistics");

  // spread is max minus min
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !channel_error_o
      |-> spread_o == $signed({1'b0, max_value_o} - {1'b0, min_value_o}))
    else $error("spread does not match max minus min");

  // a tracked channel always has min at or below max
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !channel_error_o |-> min_value_o <= max_value_o)
    else $error("minimum above maximum");

endmodule

bind per_channel_min_max_mean_tracker pcmm_checker u_pcmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .min_value_o     (min_value_o),
  .max_value_o     (max_value_o),
  .spread_o        (spread_o),
  .mean_value_o    (mean_value_o),
  .channel_error_o (channel_error_o)
);
